>>> rtl/iqr_pkg.sv
// ----------------------------------------------------------------------------
// iqr_pkg: shared types and constants of the inverse quadratic root finder
// Payload structs, field widths, command and result codes, register map.
// ----------------------------------------------------------------------------
package iqr_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned TolWidth   = 31;
  localparam int unsigned IterWidth  = 6;
  localparam int unsigned KindWidth  = 2;
  localparam int unsigned AddrWidth  = 3;
  localparam int unsigned DataWidth  = 32;

  typedef logic signed [ValueWidth-1:0] value_t;
  typedef value_t window_t [3];

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdValue = 1'b1;

  localparam logic [KindWidth-1:0] KindRequest  = 2'd0;
  localparam logic [KindWidth-1:0] KindRoot     = 2'd1;
  localparam logic [KindWidth-1:0] KindDiverged = 2'd2;

  // Register index is taken from address bit 2.
  localparam logic RegTolerance = 1'b0;
  localparam logic RegLimit     = 1'b1;

  localparam logic [TolWidth-1:0]  TolReset   = 31'd655;
  localparam logic [IterWidth-1:0] LimitReset = 6'd50;

  typedef struct packed {
    logic   cmd;
    value_t point;
    value_t value;
  } in_item_t;

  typedef struct packed {
    logic [KindWidth-1:0] kind;
    value_t               estimate;
    logic [IterWidth-1:0] iterations;
  } out_item_t;

endpackage

>>> rtl/iqr_solver.sv
// ----------------------------------------------------------------------------
// iqr_solver: inverse quadratic interpolation estimate on one shared wide adder
// A shift-add multiplier, the numerator accumulation and a restoring
// division all run through the same adder under a small sequencer.
// ----------------------------------------------------------------------------
module iqr_solver (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  iqr_pkg::value_t x_i [3],
  input  iqr_pkg::value_t y_i [3],
  output logic            done_o,
  output iqr_pkg::value_t estimate_o
);
  import iqr_pkg::*;

  localparam int unsigned W  = ValueWidth;
  localparam int unsigned MB = W + 1;
  localparam int unsigned WW = 4 * W + 4;
  localparam int unsigned CW = $clog2(MB);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_POST = 3'd2;
  localparam logic [2:0] S_ABSN = 3'd3;
  localparam logic [2:0] S_ABSD = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  // Program steps that end in something other than a plain product.
  localparam logic [3:0] PiDet   = 4'd1;
  localparam logic [3:0] PiTerm1 = 4'd4;
  localparam logic [3:0] PiTerm2 = 4'd7;
  localparam logic [3:0] PiTerm3 = 4'd10;

  logic [2:0]    st_q, st_d;
  logic [3:0]    pi_q, pi_d, pi_nx;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [WW-1:0] acc_q, acc_d, a_q, a_d, det_q, det_d, num_q, num_d;
  logic [MB-1:0] b_q, b_d;
  logic          sgn_q, sgn_d;
  value_t        est_q, est_d;

  logic [MB-1:0] xe [3];
  logic [MB-1:0] ye [3];
  logic [MB-1:0] d01, d02, d12, a_small, b_fac;
  logic          a_from_acc;
  logic [WW-1:0] opa, opb, sum;
  logic          sub;
  logic [W-2:0]  mag;

  for (genvar k = 0; k < 3; k++) begin : g_ext
    assign xe[k] = {x_i[k][W-1], x_i[k]};
    assign ye[k] = {y_i[k][W-1], y_i[k]};
  end

  assign d01 = ye[0] - ye[1];
  assign d02 = ye[0] - ye[2];
  assign d12 = ye[1] - ye[2];

  assign pi_nx = (st_q == S_IDLE) ? 4'd0 : pi_q + 4'd1;

  always_comb begin
    a_small    = d01;
    b_fac      = d02;
    a_from_acc = 1'b1;
    case (pi_nx)
      4'd0:    begin a_small = d01; b_fac = d02; a_from_acc = 1'b0; end
      4'd1:    b_fac = d12;
      4'd2:    begin a_small = xe[0]; b_fac = ye[1]; a_from_acc = 1'b0; end
      4'd3:    b_fac = ye[2];
      4'd4:    b_fac = d12;
      4'd5:    begin a_small = xe[1]; b_fac = ye[0]; a_from_acc = 1'b0; end
      4'd6:    b_fac = ye[2];
      4'd7:    b_fac = d02;
      4'd8:    begin a_small = xe[2]; b_fac = ye[0]; a_from_acc = 1'b0; end
      4'd9:    b_fac = ye[1];
      4'd10:   b_fac = d01;
      default: begin a_small = d01; b_fac = d02; a_from_acc = 1'b0; end
    endcase
  end

  // The one shared adder/subtractor.
  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    unique case (st_q)
      S_MUL: begin
        opa = {acc_q[WW-2:0], 1'b0};
        opb = b_q[MB-1] ? a_q : '0;
        // The multiplier's top bit carries negative weight.
        sub = b_q[MB-1] && (cnt_q == CW'(MB - 1));
      end
      S_POST: begin
        opa = num_q;
        opb = acc_q;
        sub = (pi_q == PiTerm2);
      end
      S_ABSN: begin
        opb = num_q;
        sub = 1'b1;
      end
      S_ABSD: begin
        opb = det_q;
        sub = 1'b1;
      end
      S_DIV: begin
        opa = num_q;
        opb = a_q;
        sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = opa + (sub ? ~opb : opb) + WW'(sub);
  assign mag = {b_q[W-3:0], ~sum[WW-1]};

  always_comb begin
    st_d  = st_q;
    pi_d  = pi_q;
    cnt_d = cnt_q;
    acc_d = acc_q;
    a_d   = a_q;
    b_d   = b_q;
    det_d = det_q;
    num_d = num_q;
    sgn_d = sgn_q;
    est_d = est_q;
    unique case (st_q)
      S_IDLE: begin
        if (start_i) begin
          pi_d  = pi_nx;
          a_d   = {{(WW-MB){a_small[MB-1]}}, a_small};
          b_d   = b_fac;
          acc_d = '0;
          cnt_d = CW'(MB - 1);
          st_d  = S_MUL;
        end
      end
      S_MUL: begin
        acc_d = sum;
        b_d   = {b_q[MB-2:0], 1'b0};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) st_d = S_POST;
      end
      S_POST: begin
        // Load the next multiplication unless the program ends here.
        pi_d  = pi_nx;
        a_d   = a_from_acc ? acc_q : {{(WW-MB){a_small[MB-1]}}, a_small};
        b_d   = b_fac;
        acc_d = '0;
        cnt_d = CW'(MB - 1);
        st_d  = S_MUL;
        if (pi_q == PiDet) begin
          det_d = acc_q;
          if (acc_q == '0) begin
            // Singular system: fall back to the oldest abscissa.
            est_d = x_i[0];
            st_d  = S_FIN;
          end
        end else if (pi_q == PiTerm1) begin
          num_d = acc_q;
        end else if (pi_q == PiTerm2) begin
          num_d = sum;
        end else if (pi_q == PiTerm3) begin
          num_d = sum;
          st_d  = S_ABSN;
        end
      end
      S_ABSN: begin
        sgn_d = num_q[WW-1] ^ det_q[WW-1];
        if (num_q[WW-1]) num_d = sum;
        st_d = S_ABSD;
      end
      S_ABSD: begin
        a_d   = (det_q[WW-1] ? sum : det_q) << (W - 1);
        b_d   = '0;
        cnt_d = CW'(W - 1);
        st_d  = S_DIV;
      end
      S_DIV: begin
        if (!sum[WW-1]) num_d = sum;
        b_d   = {b_q[MB-2:0], ~sum[WW-1]};
        a_d   = {1'b0, a_q[WW-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == CW'(W - 1) && !sum[WW-1]) begin
          // Quotient magnitude reaches the top bit: saturate.
          est_d = sgn_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
          st_d  = S_FIN;
        end else if (cnt_q == '0) begin
          est_d = sgn_q ? -{1'b0, mag} : {1'b0, mag};
          st_d  = S_FIN;
        end
      end
      S_FIN:   st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_IDLE;
      pi_q  <= '0;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      pi_q  <= pi_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
    det_q <= det_d;
    num_q <= num_d;
    sgn_q <= sgn_d;
    est_q <= est_d;
  end

  assign done_o     = (st_q == S_FIN);
  assign estimate_o = est_q;

endmodule

>>> rtl/inverse_quadratic_root_iteration_top.sv
// ----------------------------------------------------------------------------
// inverse_quadratic_root_iteration_top: fixed-point root finder
// Holds the three-point window, makes the stop decisions and hands the
// interpolation to the shared-adder solver.
// ----------------------------------------------------------------------------
// Three load transfers set up the window; the block then answers with a
// request for f at a new estimate, a converged root or a divergence flag,
// and each delivered function value moves the window on by one. An
// estimate comes from a single wide adder reused for eleven shift-add
// multiplications and up to 32 division steps. Input stall stays high
// while a transfer is processed, until its result moves into the output
// register; a waiting result does not hold up the next input transfer.
module inverse_quadratic_root_iteration_top (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  iqr_pkg::in_item_t                        in_data_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output iqr_pkg::out_item_t                       out_data_o,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [iqr_pkg::AddrWidth-1:0]            paddr,
  input  logic [iqr_pkg::DataWidth-1:0]            pwdata,
  output logic [iqr_pkg::DataWidth-1:0]            prdata,
  output logic                                     pready
);
  import iqr_pkg::*;

  localparam logic [2:0] T_IDLE   = 3'd0;
  localparam logic [2:0] T_SWAP   = 3'd1;
  localparam logic [2:0] T_DECIDE = 3'd2;
  localparam logic [2:0] T_CALC   = 3'd3;
  localparam logic [2:0] T_EMIT   = 3'd4;

  logic [2:0]           st_q, st_d;
  value_t               x_q [3];
  value_t               x_d [3];
  value_t               y_q [3];
  value_t               y_d [3];
  value_t               pend_q, pend_d;
  logic [1:0]           lc_q, lc_d, idx;
  logic [IterWidth-1:0] it_q, it_d, lim_q;
  logic [TolWidth-1:0]  tol_q;
  out_item_t            res_q, res_d, out_q;
  logic                 out_valid_q;
  logic                 accept, cfg_wr, start, done;
  logic [ValueWidth-1:0] mag;
  value_t               est;
  value_t               sx [3];
  value_t               sy [3];
  value_t               tv;

  assign in_stall_o = (st_q != T_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign cfg_wr     = psel && penable && pwrite;
  assign idx        = (lc_q == 2'd3) ? 2'd0 : lc_q;
  assign mag        = y_q[2][ValueWidth-1] ? -y_q[2] : y_q[2];
  assign start      = (st_q == T_DECIDE) && !(mag < {{(ValueWidth-TolWidth){1'b0}}, tol_q})
                      && !(it_q >= lim_q);

  iqr_solver u_solver (
    .clk_i,
    .rst_ni,
    .start_i    (start),
    .x_i        (x_q),
    .y_i        (y_q),
    .done_o     (done),
    .estimate_o (est)
  );

  // Two dependent conditional swaps that move the smallest abscissa of the start window into the last slot.
  always_comb begin
    sx = x_q;
    sy = y_q;
    tv = '0;
    if (sx[1] > sx[0]) begin
      tv = sx[0]; sx[0] = sx[1]; sx[1] = tv;
      tv = sy[0]; sy[0] = sy[1]; sy[1] = tv;
    end
    if (sx[2] > sx[1]) begin
      tv = sx[1]; sx[1] = sx[2]; sx[2] = tv;
      tv = sy[1]; sy[1] = sy[2]; sy[2] = tv;
    end
  end

  always_comb begin
    st_d   = st_q;
    x_d    = x_q;
    y_d    = y_q;
    pend_d = pend_q;
    lc_d   = lc_q;
    it_d   = it_q;
    res_d  = res_q;
    unique case (st_q)
      T_IDLE: begin
        if (accept) begin
          if (in_data_i.cmd == CmdLoad) begin
            if (lc_q == 2'd3) it_d = '0;
            x_d[idx] = in_data_i.point;
            y_d[idx] = in_data_i.value;
            lc_d     = idx + 2'd1;
            if (idx == 2'd2) st_d = T_SWAP;
          end else if (lc_q == 2'd3) begin
            x_d  = '{x_q[1], x_q[2], pend_q};
            y_d  = '{y_q[1], y_q[2], in_data_i.value};
            it_d = it_q + 1'b1;
            st_d = T_DECIDE;
          end
        end
      end
      T_SWAP: begin
        x_d  = sx;
        y_d  = sy;
        st_d = T_DECIDE;
      end
      T_DECIDE: begin
        if (mag < {{(ValueWidth-TolWidth){1'b0}}, tol_q}) begin
          res_d = '{kind: KindRoot, estimate: x_q[2], iterations: it_q};
          lc_d  = '0;
          it_d  = '0;
          st_d  = T_EMIT;
        end else if (it_q >= lim_q) begin
          res_d = '{kind: KindDiverged, estimate: '0, iterations: '0};
          lc_d  = '0;
          it_d  = '0;
          st_d  = T_EMIT;
        end else begin
          st_d = T_CALC;
        end
      end
      T_CALC: begin
        if (done) begin
          pend_d = est;
          res_d  = '{kind: KindRequest, estimate: est, iterations: '0};
          st_d   = T_EMIT;
        end
      end
      T_EMIT: begin
        if (!out_valid_q || !out_stall_i) st_d = T_IDLE;
      end
      default: st_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= T_IDLE;
      lc_q        <= '0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
      tol_q       <= TolReset;
      lim_q       <= LimitReset;
    end else begin
      st_q <= st_d;
      lc_q <= lc_d;
      it_q <= it_d;
      if (st_q == T_EMIT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        if (paddr[2] == RegTolerance) tol_q <= pwdata[TolWidth-1:0];
        else                          lim_q <= pwdata[IterWidth-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    pend_q <= pend_d;
    res_q  <= res_d;
    if (st_q == T_EMIT && (!out_valid_q || !out_stall_i)) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == RegLimit) ? {{(DataWidth-IterWidth){1'b0}}, lim_q}
                                              : {{(DataWidth-TolWidth){1'b0}}, tol_q};

endmodule

>>> rtl/iqr_checker.sv
// ----------------------------------------------------------------------------
// iqr_checker: port-level assertions for the root finder
// Watches the channels of the top level over time; bound to the top level.
// ----------------------------------------------------------------------------
module iqr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input iqr_pkg::out_item_t  out_data_o
);
  import iqr_pkg::*;

  // A stalled result stays on the port unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // A fresh result only appears after the block was busy with an input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a busy cycle");

  // Divergence carries neither a root nor an iteration count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindDiverged |->
      out_data_o.estimate == '0 && out_data_o.iterations == '0)
    else $error("divergence result not cleared");

  // Evaluation requests report no iteration count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.kind == KindRequest |-> out_data_o.iterations == '0)
    else $error("request carries an iteration count");

endmodule

bind inverse_quadratic_root_iteration_top iqr_checker u_iqr_checker (.*);

>>> test/inverse_quadratic_root_iteration_top_test.sv
// ----------------------------------------------------------------------------
// inverse_quadratic_root_iteration_top_test: regression for the root finder
// Loads start pairs and delivers function values with random gaps, predicts
// every request, root and divergence result with exact wide arithmetic and
// checks the results in order under random output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inverse_quadratic_root_iteration_top_test;
  import iqr_pkg::*;

  typedef logic signed [199:0] wide_t;

  localparam logic [AddrWidth-1:0] AddrTolerance = 3'd0;
  localparam logic [AddrWidth-1:0] AddrLimit     = 3'd4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic pready;

  inverse_quadratic_root_iteration_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Shadow state of the root finder.
  value_t xs [3];
  value_t ys [3];
  value_t pending_x;
  int unsigned loaded;
  logic [IterWidth-1:0] iter_cnt;
  logic [TolWidth-1:0] tol_reg = TolReset;
  logic [IterWidth-1:0] limit_reg = LimitReset;

  in_item_t  pending_items [$];
  out_item_t expected_results [$];
  int unsigned mismatches = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  logic no_idle = 1'b0;
  logic hold_output = 1'b0;

  function automatic value_t interpolate();
    wide_t x0, x1, x2, y0, y1, y2, d01, d02, d12, det, num, q;
    x0 = xs[0]; x1 = xs[1]; x2 = xs[2];
    y0 = ys[0]; y1 = ys[1]; y2 = ys[2];
    d01 = y0 - y1; d02 = y0 - y2; d12 = y1 - y2;
    det = d01 * d02 * d12;
    if (det == 0) return xs[0];
    num = x0 * y1 * y2 * d12 - x1 * y0 * y2 * d02 + x2 * y0 * y1 * d01;
    q = num / det;
    if (q > wide_t'(32'sh7fffffff)) return 32'sh7fffffff;
    if (q < wide_t'(-64'sh80000000)) return 32'sh80000000;
    return q[31:0];
  endfunction

  function automatic out_item_t decide_next();
    out_item_t r;
    logic [32:0] mag;
    r = '0;
    mag = ys[2][31] ? 33'(-{ys[2][31], ys[2]}) : 33'(ys[2]);
    if (mag < {2'b0, tol_reg}) begin
      r.kind = KindRoot; r.estimate = xs[2]; r.iterations = iter_cnt;
      loaded = 0; iter_cnt = '0;
    end else if (iter_cnt >= limit_reg) begin
      r.kind = KindDiverged;
      loaded = 0; iter_cnt = '0;
    end else begin
      pending_x = interpolate();
      r.kind = KindRequest; r.estimate = pending_x;
    end
    return r;
  endfunction

  function automatic void swap_pairs(int a, int b);
    value_t t;
    t = xs[a]; xs[a] = xs[b]; xs[b] = t;
    t = ys[a]; ys[a] = ys[b]; ys[b] = t;
  endfunction

  // Advances the shadow state by one accepted transfer.
  function automatic void predict_transfer(in_item_t it);
    if (it.cmd == CmdLoad) begin
      if (loaded >= 3) begin
        loaded = 0; iter_cnt = '0;
      end
      xs[loaded] = it.point; ys[loaded] = it.value;
      loaded++;
      if (loaded < 3) return;
      if (xs[1] > xs[0]) swap_pairs(0, 1);
      if (xs[2] > xs[1]) swap_pairs(1, 2);
      expected_results.push_back(decide_next());
    end else if (loaded == 3) begin
      xs[0] = xs[1]; xs[1] = xs[2]; xs[2] = pending_x;
      ys[0] = ys[1]; ys[1] = ys[2]; ys[2] = it.value;
      iter_cnt = iter_cnt + 1'b1;
      expected_results.push_back(decide_next());
    end
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 80);
  endfunction

  // Sender.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_transfer(in_data_i);
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_items.size() > 0) begin
          in_data_i <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver and result check.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d estimate %0d iterations %0d",
                     out_data_o.kind, out_data_o.estimate, out_data_o.iterations);
        end else begin
          want = expected_results.pop_front();
          if (out_data_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: kind %0d/%0d estimate %0d/%0d iterations %0d/%0d",
                       want.kind, out_data_o.kind, want.estimate, out_data_o.estimate,
                       want.iterations, out_data_o.iterations);
          end
        end
      end
      if (hold_output) begin
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        out_stall_i <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else begin
        out_stall_i <= 1'b0;
        recv_gap <= pick_gap();
      end
    end
  end

  task automatic write_reg(logic [AddrWidth-1:0] addr, logic [DataWidth-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrTolerance) tol_reg = data[TolWidth-1:0];
    else limit_reg = data[IterWidth-1:0];
  endtask

  function automatic value_t pick_value();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2, 3:    return $urandom_range(0, 2000) - 1000;
      4:       return '0;
      5:       return 32'sh80000000;
      6:       return 32'sh7fffffff;
      default: return $urandom_range(0, 32'h200000) - 32'h100000;
    endcase
  endfunction

  function automatic value_t pick_point();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $urandom_range(0, 32'h80000) - 32'h40000;
  endfunction

  function automatic void add_item(logic cmd, value_t pt, value_t v);
    in_item_t it;
    it.cmd = cmd; it.point = pt; it.value = v;
    pending_items.push_back(it);
  endfunction

  // Mostly whole runs with random content; some broken runs and stray values.
  task automatic queue_runs(int unsigned count);
    int unsigned n, loads, k, i;
    value_t shared;
    n = 0;
    while (n < count) begin
      k = $urandom_range(0, 19);
      if (k == 0) begin
        add_item(CmdValue, $urandom, $urandom);
        n++;
      end else begin
        loads = (k == 1) ? $urandom_range(1, 2) : 3;
        shared = pick_value();
        for (i = 0; i < loads; i++)
          add_item(CmdLoad, pick_point(), (k == 2) ? shared : pick_value());
        k = $urandom_range(0, 12);
        for (i = 0; i < k; i++) add_item(CmdValue, $urandom, pick_value());
        n += loads + k;
      end
    end
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    repeat (500) @(posedge clk_i);
  endtask

  initial begin
    pending_x = '0; loaded = 0; iter_cnt = '0;
    foreach (xs[i]) begin
      xs[i] = '0; ys[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, equal values, immediate root, abandoned run.
    add_item(CmdValue, 32'sh7fffffff, 32'sh7fffffff);
    add_item(CmdLoad, 32'sh80000000, 32'sh80000000);
    add_item(CmdLoad, 32'sh7fffffff, 32'sh7fffffff);
    add_item(CmdLoad, 32'sh0, 32'sh10000);
    add_item(CmdValue, 32'sh0, 32'sh80000000);
    add_item(CmdValue, 32'sh0, 32'sh7fffffff);
    add_item(CmdLoad, 32'sh10000, 32'sh5000);
    add_item(CmdLoad, 32'sh20000, 32'sh5000);
    add_item(CmdLoad, 32'sh30000, 32'sh5000);
    add_item(CmdValue, 32'sh0, 32'sh5000);
    add_item(CmdLoad, 32'sh10000, -32'sh10000);
    add_item(CmdLoad, 32'sh30000, 32'sh10000);
    add_item(CmdLoad, 32'sh20000, 32'sh0);
    add_item(CmdLoad, -32'sh20000, -32'sh30000);
    add_item(CmdLoad, 32'sh20000, 32'sh20000);
    add_item(CmdLoad, 32'sh0, 32'sh8000);
    add_item(CmdValue, 32'sh0, 32'sh100);
    add_item(CmdLoad, 32'sh40000, 32'sh7fffffff);
    add_item(CmdLoad, 32'sh1, 32'sh80000000);
    add_item(CmdLoad, -32'sh1, 32'sh1);
    add_item(CmdValue, -32'sh1, 32'sh0);
    drain();

    queue_runs(300);
    drain();

    write_reg(AddrTolerance, 32'd0);
    write_reg(AddrLimit, 32'd1);
    queue_runs(200);
    drain();

    write_reg(AddrTolerance, 32'h7fffffff);
    write_reg(AddrLimit, 32'd63);
    no_idle <= 1'b1;
    queue_runs(150);
    drain();

    no_idle <= 1'b0;
    write_reg(AddrTolerance, 32'h10000);
    write_reg(AddrLimit, 32'd6);
    queue_runs(400);
    drain();

    write_reg(AddrTolerance, $urandom_range(1, 32'h2000));
    write_reg(AddrLimit, $urandom_range(2, 12));
    queue_runs(400);
    drain();

    if (mismatches == 0 && expected_results.size() == 0)
      $display("inverse_quadratic_root_iteration_top regression: pass");
    else
      $display("inverse_quadratic_root_iteration_top regression: fail");
    $finish;
  end

  // A long output hold while the sender keeps offering transfers.
  initial begin
    wait (rst_ni);
    repeat (150000) @(posedge clk_i);
    hold_output <= 1'b1;
    repeat (4000) @(posedge clk_i);
    hold_output <= 1'b0;
  end

  initial begin
    #40ms;
    $display("inverse_quadratic_root_iteration_top regression: fail");
    $finish;
  end

endmodule

>>> sim.f
rtl/iqr_pkg.sv
rtl/iqr_solver.sv
rtl/inverse_quadratic_root_iteration_top.sv
rtl/iqr_checker.sv
test/inverse_quadratic_root_iteration_top_test.sv
